// File: design/lph_pkg.sv
// Package for the linear probe key table: widths, codes, states and the status bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lph_pkg;
  localparam int LOG2_SLOTS_MAX = 10;
  localparam int PHYS_SLOTS = 1 << LOG2_SLOTS_MAX;
  localparam int KEY_W = 64;
  localparam int HASH_W = 32;
  localparam int SLOT_W = LOG2_SLOTS_MAX;
  localparam int LG_W = 4;
  localparam int CNT_W = 10;
  localparam int Q_DEPTH = 2;
  localparam int ENT_W = KEY_W + HASH_W;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_MISS  = 3'd1,
    ST_DUP   = 3'd2,
    ST_FULL  = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_P_RD,
    S_P_CHK,
    S_R_RD,
    S_R_CHK,
    S_S_RD,
    S_S_CHK,
    S_CLR,
    S_OUT
  } bstate_t;

  // one classified operation handed from front to back
  typedef struct packed {
    kind_t            kind;
    logic             bad;      // null key or remove slot out of range
    logic [KEY_W-1:0] key;
    logic [HASH_W-1:0] hash;
    slot_t            start;    // probe start or remove slot
    slot_t            mask;
  } op_t;

  localparam int OP_W = $bits(op_t);
endpackage
`default_nettype wire

// File: design/lph_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: design/lph_front.sv
// Front end: accepts operations, masks the hash, flags null keys and remove slots beyond the mask.
// Depends on lph_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lph_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         valid_in,
  output logic                              stall_in,
  input  wire logic [1:0]                   kind,
  input  wire logic [lph_pkg::KEY_W-1:0]    key,
  input  wire logic [lph_pkg::HASH_W-1:0]   probe_hash,
  input  wire logic [lph_pkg::SLOT_W-1:0]   slot_index,
  input  wire logic [lph_pkg::LG_W-1:0]     log2_slots,
  output logic                              q_valid,
  input  wire logic                         q_take,
  output lph_pkg::op_t                      q_op
);
  import lph_pkg::*;

  op_t             ent [Q_DEPTH];
  logic            rd_ptr;
  logic            wr_ptr;
  logic [1:0]      fill;
  logic            push;
  logic            pop;
  op_t             op_new;
  logic [LG_W-1:0] lg;
  slot_t           mask;

  always_comb begin
    lg = (log2_slots > LG_W'(LOG2_SLOTS_MAX)) ? LG_W'(LOG2_SLOTS_MAX) : log2_slots;
    mask = slot_t'((32'd1 << lg) - 32'd1);
    op_new.kind = kind_t'(kind);
    op_new.key = key;
    op_new.hash = probe_hash;
    op_new.mask = mask;
    if (kind_t'(kind) == KIND_REMOVE) begin
      op_new.start = slot_index;
      op_new.bad = slot_index > mask;
    end else begin
      op_new.start = slot_t'(probe_hash) & mask;
      op_new.bad = key == '0;
    end
  end

  assign stall_in = fill == 2'(Q_DEPTH);
  assign push = valid_in && !stall_in;
  assign q_valid = fill != 2'd0;
  assign pop = q_valid && q_take;
  assign q_op = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent[wr_ptr] <= op_new;
  end

`ifndef SYNTHESIS
  a_fill_max: assert property (@(posedge clk) disable iff (rst) fill <= 2'(Q_DEPTH))
    else $error("queue overfilled");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) fill == 2'd0 |-> !pop)
    else $error("pop from empty queue");
  a_fill_track: assert property (@(posedge clk) disable iff (rst)
      push && !pop |=> fill == $past(fill) + 2'd1)
    else $error("fill count lost a push");
`endif
endmodule
`default_nettype wire

// File: design/lph_back.sv
// Back end: probe, backward-shift remove and clear sweep over the slot memory.
// Depends on lph_pkg and lph_ram.
`timescale 1ns / 1ps
`default_nettype none
module lph_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  output logic                              q_take,
  input  wire lph_pkg::op_t                 q_op,
  output logic                              valid_out,
  input  wire logic                         stall_out,
  output logic [2:0]                        status,
  output logic [lph_pkg::SLOT_W-1:0]        result_slot,
  output logic [lph_pkg::CNT_W-1:0]         key_count
);
  import lph_pkg::*;

  bstate_t state, state_next;
  op_t     op;
  slot_t   cur, cur_next;
  slot_t   hole, hole_next;
  slot_t   steps, steps_next;
  slot_t   moves, moves_next;
  logic    moved, moved_next;
  logic    sweep, sweep_next;
  logic [CNT_W-1:0] held, held_next;
  status_t st_r, st_next;
  slot_t   res_r, res_next;

  logic    out_full;
  logic    out_load;

  logic    we;
  slot_t   addr;
  logic [ENT_W-1:0] wdata;
  logic [ENT_W-1:0] rdata;
  logic [KEY_W-1:0] rkey;
  slot_t   rstart;
  logic    hit_run;
  logic    k_we;
  logic [KEY_W-1:0] kw;

  // slot key memory: clear is a sweep; reset sweeps too
  lph_ram #(.WIDTH(ENT_W), .DEPTH(PHYS_SLOTS)) u_slots (
    .clk  (clk),
    .we   (we),
    .addr (addr),
    .wdata(wdata),
    .rdata(rdata)
  );

  assign rkey = rdata[ENT_W-1 -: KEY_W];
  assign rstart = slot_t'(rdata[HASH_W-1:0]) & op.mask;
  assign kw = k_we ? op.key : '0;

  always_comb begin
    if (hole <= cur) hit_run = (hole < rstart) && (rstart <= cur);
    else hit_run = (hole < rstart) || (rstart <= cur);
  end

  always_comb begin
    state_next = state;
    cur_next = cur;
    hole_next = hole;
    steps_next = steps;
    moves_next = moves;
    moved_next = moved;
    sweep_next = sweep;
    held_next = held;
    st_next = st_r;
    res_next = res_r;
    we = 1'b0;
    addr = cur;
    k_we = 1'b0;
    wdata = {KEY_W'(0), op.hash};
    q_take = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid && !out_full) begin
          q_take = 1'b1;
          cur_next = q_op.start;
          steps_next = '0;
          moves_next = '0;
          moved_next = 1'b0;
          st_next = ST_OK;
          res_next = '0;
          case (q_op.kind)
            KIND_INSERT: begin
              if (q_op.bad) begin
                st_next = ST_MISS;
                state_next = S_OUT;
              end else if (held >= CNT_W'(q_op.mask)) begin
                st_next = ST_FULL;
                state_next = S_OUT;
              end else begin
                state_next = S_P_RD;
              end
            end
            KIND_QUERY: begin
              st_next = ST_MISS;
              state_next = q_op.bad ? S_OUT : S_P_RD;
            end
            KIND_REMOVE: begin
              if (q_op.bad) begin
                st_next = ST_EMPTY;
                state_next = S_OUT;
              end else begin
                state_next = S_R_RD;
              end
            end
            KIND_CLEAR: begin
              cur_next = '0;
              held_next = '0;
              state_next = S_CLR;
            end
            default: state_next = S_OUT;
          endcase
        end
      end
      S_P_RD: state_next = S_P_CHK;
      S_P_CHK: begin
        if (rkey == '0) begin
          if (op.kind == KIND_INSERT) begin
            we = 1'b1;
            k_we = 1'b1;
            held_next = held + 1'b1;
            st_next = ST_OK;
            res_next = cur;
          end
          state_next = S_OUT;
        end else if (rkey == op.key) begin
          if (op.kind == KIND_INSERT) st_next = ST_DUP;
          else begin
            st_next = ST_OK;
            res_next = cur;
          end
          state_next = S_OUT;
        end else if (steps == op.mask) begin
          st_next = (op.kind == KIND_INSERT) ? ST_FULL : ST_MISS;
          state_next = S_OUT;
        end else begin
          steps_next = steps + 1'b1;
          cur_next = (cur + 1'b1) & op.mask;
          state_next = S_P_RD;
        end
      end
      S_R_RD: state_next = S_R_CHK;
      S_R_CHK: begin
        // after a move, cur is the new hole and rdata is stale
        if (moves == '0 && rkey == '0) begin
          st_next = ST_EMPTY;
          state_next = S_OUT;
        end else begin
          if (moves == '0 && held != '0) held_next = held - 1'b1;
          we = 1'b1;
          hole_next = cur;
          steps_next = '0;
          cur_next = (cur + 1'b1) & op.mask;
          state_next = S_S_RD;
        end
      end
      S_S_RD: state_next = S_S_CHK;
      S_S_CHK: begin
        // steps counts completed advances less one; the model's "steps > mask" bound
        if (rkey == '0 || steps == op.mask) begin
          state_next = S_OUT;
        end else if (!hit_run) begin
          // move entry back into the hole, this slot becomes the new hole
          we = 1'b1;
          addr = hole;
          wdata = rdata;
          if (moves == op.mask) begin
            moved_next = 1'b1;
            hole_next = cur;
            state_next = S_CLR;
          end else begin
            moves_next = moves + 1'b1;
            hole_next = cur;
            state_next = S_R_CHK;
          end
        end else begin
          steps_next = steps + 1'b1;
          cur_next = (cur + 1'b1) & op.mask;
          state_next = S_S_RD;
        end
      end
      S_CLR: begin
        if (moved) begin
          // last-move cap: empty the source slot
          we = 1'b1;
          addr = hole;
          state_next = S_OUT;
        end else begin
          we = 1'b1;
          cur_next = cur + 1'b1;
          if (cur == slot_t'(PHYS_SLOTS - 1)) begin
            if (sweep) begin
              sweep_next = 1'b0;
              state_next = S_IDLE;
            end else begin
              state_next = S_OUT;
            end
          end
        end
      end
      S_OUT: begin
        out_load = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (k_we) wdata = {kw, op.hash};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cur <= '0;
      sweep <= 1'b1;
      held <= '0;
      out_full <= 1'b0;
      moved <= 1'b0;
    end else begin
      state <= state_next;
      cur <= cur_next;
      sweep <= sweep_next;
      held <= held_next;
      moved <= moved_next;
      if (out_load) out_full <= 1'b1;
      else if (!stall_out) out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) op <= q_op;
    hole <= hole_next;
    steps <= steps_next;
    moves <= moves_next;
    st_r <= st_next;
    res_r <= res_next;
    if (out_load) begin
      status <= st_r;
      result_slot <= res_r;
      key_count <= held;
    end
  end

  assign valid_out = out_full;

`ifndef SYNTHESIS
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
      q_take |-> state == S_IDLE && !out_full)
    else $error("took op while busy");
  a_out_once: assert property (@(posedge clk) disable iff (rst)
      out_load |=> out_full && state == S_IDLE)
    else $error("result not registered");
  a_held_range: assert property (@(posedge clk) disable iff (rst)
      state == S_P_CHK && we && op.kind == KIND_INSERT |-> held < CNT_W'(op.mask))
    else $error("insert into full table");
`endif
endmodule
`default_nettype wire

// File: design/linear_probe_hash_map_core.sv
// Linear probe key table core: config register, front queue and back engine.
// Depends on lph_pkg, lph_front, lph_back.
// The back end handles one operation at a time, with one read per slot.
// Reset: sync active-high; keys_held zero, log2_slots 10; a sweep empties every slot
// after reset, with input transfers queued meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_map_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [lph_pkg::LG_W-1:0]     cfg_wdata,
  input  wire logic                         valid_in,
  output logic                              stall_in,
  input  wire logic [1:0]                   kind,
  input  wire logic [lph_pkg::KEY_W-1:0]    key,
  input  wire logic [lph_pkg::HASH_W-1:0]   probe_hash,
  input  wire logic [lph_pkg::SLOT_W-1:0]   slot_index,
  output logic                              valid_out,
  input  wire logic                         stall_out,
  output logic [2:0]                        status,
  output logic [lph_pkg::SLOT_W-1:0]        result_slot,
  output logic [lph_pkg::CNT_W-1:0]         key_count
);
  import lph_pkg::*;

  logic [LG_W-1:0] log2_slots;
  logic            q_valid;
  logic            q_take;
  op_t             q_op;

  always_ff @(posedge clk) begin
    if (rst) log2_slots <= LG_W'(LOG2_SLOTS_MAX);
    else if (cfg_we) log2_slots <= cfg_wdata;
  end

  lph_front u_front (
    .clk(clk), .rst(rst), .valid_in(valid_in), .stall_in(stall_in), .kind(kind),
    .key(key), .probe_hash(probe_hash), .slot_index(slot_index), .log2_slots(log2_slots),
    .q_valid(q_valid), .q_take(q_take), .q_op(q_op)
  );

  lph_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_take(q_take), .q_op(q_op),
    .valid_out(valid_out), .stall_out(stall_out), .status(status),
    .result_slot(result_slot), .key_count(key_count)
  );
endmodule
`default_nettype wire

// File: tb/linear_probe_hash_map_core_tb.sv
// Self-checking testbench for linear_probe_hash_map_core: directed table, then random
// phases over several table sizes and idle patterns, each result checked in order.
// Depends on lph_pkg and the core RTL.
`timescale 1ns / 1ps
module linear_probe_hash_map_core_tb;
  import lph_pkg::*;

  typedef struct {
    status_t            st;
    slot_t              slot;
    logic [CNT_W-1:0]   cnt;
  } table_result_t;

  typedef struct {
    int                 lg;
    kind_t              kind;
    logic [KEY_W-1:0]   key;
    logic [HASH_W-1:0]  hash;
    slot_t              idx;
    bit                 typed;
    table_result_t      res;
  } op_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [LG_W-1:0]      cfg_wdata;
  logic                 valid_in;
  logic                 stall_in;
  logic [1:0]           kind;
  logic [KEY_W-1:0]     key;
  logic [HASH_W-1:0]    probe_hash;
  logic [SLOT_W-1:0]    slot_index;
  logic                 valid_out;
  logic                 stall_out;
  logic [2:0]           status;
  logic [SLOT_W-1:0]    result_slot;
  logic [CNT_W-1:0]     key_count;

  linear_probe_hash_map_core u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .valid_in(valid_in), .stall_in(stall_in), .kind(kind), .key(key),
    .probe_hash(probe_hash), .slot_index(slot_index), .valid_out(valid_out),
    .stall_out(stall_out), .status(status), .result_slot(result_slot),
    .key_count(key_count)
  );

  // table shadow
  logic [KEY_W-1:0]     shadow_keys [PHYS_SLOTS];
  logic [HASH_W-1:0]    shadow_hashes [PHYS_SLOTS];
  logic [CNT_W-1:0]     shadow_count;
  logic [LG_W-1:0]      shadow_lg;

  table_result_t        results_due[$];
  op_row_t              directed_ops[$];
  int                   mismatches = 0;
  int                   ops_sent = 0;
  int                   results_seen = 0;
  int                   clears_sent = 0;
  int                   send_idle = 0;
  int                   recv_idle = 0;
  logic [KEY_W-1:0]     key_pool [16];
  logic [HASH_W-1:0]    hash_pool [16];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic slot_t probe_mask();
    int lg;
    lg = (shadow_lg > LOG2_SLOTS_MAX) ? LOG2_SLOTS_MAX : shadow_lg;
    return slot_t'((1 << lg) - 1);
  endfunction

  // start lies in cyclic interval (hole, s]
  function automatic bit in_probe_run(slot_t hole, slot_t start, slot_t s);
    if (hole <= s) return (hole < start) && (start <= s);
    return (hole < start) || (start <= s);
  endfunction

  task automatic shift_back_from(input slot_t s, input slot_t mask);
    slot_t hole;
    int moves, steps;
    bit done, move;
    moves = 0;
    done = 0;
    while (!done) begin
      hole = s;
      steps = 0;
      shadow_keys[hole] = '0;
      move = 0;
      while (!done && !move) begin
        s = slot_t'((s + 1) & mask);
        steps++;
        if (shadow_keys[s] == 0 || steps > mask) done = 1;
        else if (!in_probe_run(hole, slot_t'(shadow_hashes[s]) & mask, s)) move = 1;
      end
      if (move) begin
        shadow_keys[hole] = shadow_keys[s];
        shadow_hashes[hole] = shadow_hashes[s];
        moves++;
        if (moves > mask) begin
          shadow_keys[s] = '0;
          done = 1;
        end
      end
    end
  endtask

  task automatic apply_op(input kind_t k, input logic [KEY_W-1:0] kv,
                          input logic [HASH_W-1:0] hv, input slot_t idx,
                          output table_result_t r);
    slot_t mask, s;
    int n;
    bit stop;
    mask = probe_mask();
    r.st = ST_OK;
    r.slot = '0;
    stop = 0;
    case (k)
      KIND_INSERT: begin
        if (kv == 0) r.st = ST_MISS;
        else if (shadow_count >= mask) r.st = ST_FULL;
        else begin
          r.st = ST_FULL;
          s = slot_t'(hv) & mask;
          for (n = 0; n <= mask && !stop; n++) begin
            if (shadow_keys[s] == 0) begin
              shadow_keys[s] = kv;
              shadow_hashes[s] = hv;
              shadow_count++;
              r.st = ST_OK;
              r.slot = s;
              stop = 1;
            end else if (shadow_keys[s] == kv) begin
              r.st = ST_DUP;
              stop = 1;
            end
            s = slot_t'((s + 1) & mask);
          end
        end
      end
      KIND_QUERY: begin
        r.st = ST_MISS;
        if (kv != 0) begin
          s = slot_t'(hv) & mask;
          for (n = 0; n <= mask && !stop; n++) begin
            if (shadow_keys[s] == 0) stop = 1;
            else if (shadow_keys[s] == kv) begin
              r.st = ST_OK;
              r.slot = s;
              stop = 1;
            end
            s = slot_t'((s + 1) & mask);
          end
        end
      end
      KIND_REMOVE: begin
        if (idx > mask || shadow_keys[idx] == 0) r.st = ST_EMPTY;
        else begin
          if (shadow_count > 0) shadow_count--;
          shift_back_from(idx, mask);
        end
      end
      default: begin
        foreach (shadow_keys[i]) shadow_keys[i] = '0;
        shadow_count = '0;
      end
    endcase
    r.cnt = shadow_count;
  endtask

  task automatic set_table_size(input logic [LG_W-1:0] lg);
    valid_in <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= lg;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_lg = lg;
  endtask

  task automatic send_op(input op_row_t row);
    table_result_t r;
    while ($urandom_range(99) < send_idle) begin
      valid_in <= 1'b0;
      @(posedge clk);
    end
    valid_in <= 1'b1;
    kind <= row.kind;
    key <= row.key;
    probe_hash <= row.hash;
    slot_index <= row.idx;
    @(posedge clk);
    while (stall_in) @(posedge clk);
    apply_op(row.kind, row.key, row.hash, row.idx, r);
    results_due.push_back(row.typed ? row.res : r);
    ops_sent++;
    if (row.kind == KIND_CLEAR) clears_sent++;
  endtask

  task automatic add_row(input int lg, input kind_t k, input logic [KEY_W-1:0] kv,
                         input logic [HASH_W-1:0] hv, input int idx, input bit typed,
                         input status_t st, input int s, input int cnt);
    op_row_t row;
    row.lg = lg;
    row.kind = k;
    row.key = kv;
    row.hash = hv;
    row.idx = slot_t'(idx);
    row.typed = typed;
    row.res.st = st;
    row.res.slot = slot_t'(s);
    row.res.cnt = CNT_W'(cnt);
    directed_ops.push_back(row);
  endtask

  function automatic slot_t pick_remove_slot();
    slot_t mask, s;
    int n;
    mask = probe_mask();
    s = slot_t'($urandom) & mask;
    for (n = 0; n <= mask; n++) begin
      if (shadow_keys[s] != 0) return s;
      s = slot_t'((s + 1) & mask);
    end
    return slot_t'($urandom);
  endfunction

  always @(posedge clk) begin : rx_check
    table_result_t e;
    if (rst) stall_out <= 1'b0;
    else begin
      if (valid_out && !stall_out) begin
        results_seen++;
        if (results_due.size() == 0) report_mismatch("result with nothing expected");
        else begin
          e = results_due.pop_front();
          if (status !== e.st)
            report_mismatch($sformatf("status %0d, expected %0d", status, e.st));
          if (result_slot !== e.slot)
            report_mismatch($sformatf("result_slot %0d, expected %0d", result_slot, e.slot));
          if (key_count !== e.cnt)
            report_mismatch($sformatf("key_count %0d, expected %0d", key_count, e.cnt));
        end
      end
      stall_out <= ($urandom_range(99) < recv_idle);
    end
  end

  initial begin : stim
    int phase_lg [10] = '{10, 3, 4, 2, 1, 0, 15, 5, 6, 10};
    bit phase_clear [10] = '{1, 1, 1, 0, 1, 1, 1, 1, 0, 1};
    int send_pct [4] = '{0, 54, 0, 25};
    int recv_pct [4] = '{0, 0, 54, 25};
    op_row_t row;
    int p, i, roll;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    valid_in = 1'b0;
    kind = '0;
    key = '0;
    probe_hash = '0;
    slot_index = '0;
    foreach (shadow_keys[j]) begin
      shadow_keys[j] = '0;
      shadow_hashes[j] = '0;
    end
    shadow_count = '0;
    shadow_lg = 4'd10;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // table starts empty out of reset
    add_row(10, KIND_INSERT, 0, 32'h5, 0, 1, ST_MISS, 0, 0);
    add_row(10, KIND_QUERY, 0, 32'h5, 0, 1, ST_MISS, 0, 0);
    add_row(10, KIND_REMOVE, 0, 0, 5, 1, ST_EMPTY, 0, 0);
    add_row(10, KIND_INSERT, '1, '1, 0, 1, ST_OK, 1023, 1);
    add_row(10, KIND_INSERT, 64'd1, 32'h0, 0, 1, ST_OK, 0, 2);
    add_row(10, KIND_INSERT, 64'd2, 32'h3ff, 0, 1, ST_OK, 1, 3);
    add_row(10, KIND_QUERY, 64'd2, 32'h3ff, 0, 1, ST_OK, 1, 3);
    add_row(10, KIND_INSERT, '1, '1, 0, 1, ST_DUP, 0, 3);
    add_row(10, KIND_REMOVE, 0, 0, 1023, 1, ST_OK, 0, 2);
    add_row(10, KIND_QUERY, 64'd2, 32'h3ff, 0, 0, ST_OK, 0, 0);
    add_row(10, KIND_QUERY, 64'd5, 32'h7, 0, 1, ST_MISS, 0, 2);
    add_row(10, KIND_REMOVE, 0, 0, 1023, 0, ST_OK, 0, 0);
    add_row(0, KIND_CLEAR, 0, 0, 0, 1, ST_OK, 0, 0);
    add_row(0, KIND_INSERT, 64'd9, 32'h0, 0, 1, ST_FULL, 0, 0);
    add_row(0, KIND_REMOVE, 0, 0, 0, 1, ST_EMPTY, 0, 0);
    add_row(0, KIND_REMOVE, 0, 0, 1, 1, ST_EMPTY, 0, 0);
    add_row(0, KIND_QUERY, 64'd9, 32'h0, 0, 1, ST_MISS, 0, 0);
    add_row(1, KIND_CLEAR, 0, 0, 0, 1, ST_OK, 0, 0);
    add_row(1, KIND_INSERT, 64'd3, 32'h1, 0, 1, ST_OK, 1, 1);
    add_row(1, KIND_INSERT, 64'd4, 32'h0, 0, 1, ST_FULL, 0, 1);
    add_row(1, KIND_INSERT, 64'd3, 32'h1, 0, 1, ST_FULL, 0, 1);
    add_row(1, KIND_REMOVE, 0, 0, 2, 1, ST_EMPTY, 0, 1);
    add_row(1, KIND_QUERY, 64'd3, 32'hffff_fffd, 0, 1, ST_OK, 1, 1);

    foreach (directed_ops[j]) begin
      if (directed_ops[j].lg != shadow_lg) set_table_size(LG_W'(directed_ops[j].lg));
      send_op(directed_ops[j]);
    end

    for (p = 0; p < 10; p++) begin
      set_table_size(LG_W'(phase_lg[p]));
      send_idle = send_pct[p % 4];
      recv_idle = recv_pct[p % 4];
      for (i = 0; i < 16; i++) begin
        key_pool[i] = {$urandom, $urandom};
        if (key_pool[i] == 0) key_pool[i] = 64'd1;
        hash_pool[i] = $urandom;
      end
      row.typed = 0;
      row.lg = phase_lg[p];
      if (phase_clear[p]) begin
        row.kind = KIND_CLEAR;
        row.key = {$urandom, $urandom};
        row.hash = $urandom;
        row.idx = slot_t'($urandom);
        send_op(row);
      end
      for (i = 0; i < 103; i++) begin
        roll = $urandom_range(99);
        row.key = key_pool[$urandom_range(15)];
        row.hash = hash_pool[$urandom_range(15)];
        for (int j = 0; j < 16; j++)
          if (key_pool[j] == row.key && $urandom_range(9) != 0) row.hash = hash_pool[j];
        if ($urandom_range(19) == 0) row.key = {$urandom, $urandom};
        if ($urandom_range(29) == 0) row.key = '0;
        row.idx = slot_t'($urandom);
        if (roll < 2) row.kind = KIND_CLEAR;
        else if (roll < 48) row.kind = KIND_INSERT;
        else if (roll < 73) row.kind = KIND_QUERY;
        else begin
          row.kind = KIND_REMOVE;
          if ($urandom_range(9) < 7) row.idx = pick_remove_slot();
        end
        send_op(row);
      end
    end

    valid_in <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Ran %0d operations (%0d clears) over 10 table sizes, checked %0d results.",
             ops_sent, clears_sent, results_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// File: linear_probe_hash_map_core.f
design/lph_pkg.sv
design/lph_ram.sv
design/lph_front.sv
design/lph_back.sv
design/linear_probe_hash_map_core.sv
tb/linear_probe_hash_map_core_tb.sv
